### sv/cpc_pkg.sv
// cpc_pkg: shared widths, constants, types and rounding for the converter.
// No dependencies; used by every module of polar_cartesian_converter.
package cpc_pkg;

    localparam int DATA_WIDTH    = 24;
    localparam int FRACTION_BITS = 12;
    localparam int ITERATIONS    = 16;
    localparam int GUARD         = 12;

    // datapath widths
    localparam int W      = DATA_WIDTH + GUARD + 3;
    localparam int ZW     = 34;
    localparam int ZP_W   = DATA_WIDTH + 32;
    localparam int GP_W   = DATA_WIDTH - 1 + 24;
    localparam int ZM_W   = ZW + 32;
    localparam int GAIN_SHIFT = 24;
    localparam int ANG_SHIFT  = 60 - FRACTION_BITS;

    // pipeline depth: two entry stages, one per iteration, three exit stages
    localparam int LATENCY = 2 + ITERATIONS + 3;

    localparam logic [23:0]        GAIN_Q24       = 24'd10188014;
    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic signed [31:0] TWO_PI_Q28     = 32'sd1686629713;

    localparam logic signed [DATA_WIDTH-1:0] PI_BOUND =
        DATA_WIDTH'(36'h3243F6A88 >> (32 - FRACTION_BITS));
    localparam logic signed [DATA_WIDTH-1:0] PI_BOUND_NEG = -PI_BOUND;

    localparam logic signed [ZW-1:0] TURN_HALF        = ZW'(64'd1 << 31);
    localparam logic signed [ZW-1:0] TURN_HALF_NEG    = -TURN_HALF;
    localparam logic signed [ZW-1:0] TURN_QUARTER     = ZW'(64'd1 << 30);
    localparam logic signed [ZW-1:0] TURN_QUARTER_NEG = -TURN_QUARTER;

    localparam logic signed [W:0] SAT_HI = (W+1)'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
    localparam logic signed [W:0] SAT_LO = -SAT_HI - (W+1)'(1);
    localparam logic signed [W:0] RND_HALF = (W+1)'(1) <<< (GUARD - 1);

    // arctangent steps, 2^32 units per turn
    localparam logic [31:0] ATAN_UNITS [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic mode;      // 1: Cartesian to polar (vectoring)
        logic invalid;
        logic origin;
    } cpc_tag_t;

    typedef struct packed {
        logic signed [W-1:0]  x;
        logic signed [W-1:0]  y;
        logic signed [ZW-1:0] z;
    } cpc_vec_t;

    // drop guard bits rounding half up, then saturate
    function automatic logic signed [DATA_WIDTH-1:0] round_sat(input logic signed [W:0] v);
        logic signed [W:0] t;
        begin
            t = (v + RND_HALF) >>> GUARD;
            if (t > SAT_HI)
                t = SAT_HI;
            else if (t < SAT_LO)
                t = SAT_LO;
            return t[DATA_WIDTH-1:0];
        end
    endfunction

endpackage

### sv/cpc_pre.sv
// cpc_pre: input checks, angle scaling and gain multiply, quadrant fold.
// Two register stages feeding the CORDIC core. Depends on cpc_pkg.
module cpc_pre (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   command,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0]  first_value,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0]  second_value,
    output logic                                   out_valid,
    output cpc_pkg::cpc_tag_t                      out_tag,
    output cpc_pkg::cpc_vec_t                      out_vec
);
    import cpc_pkg::*;

    localparam logic signed [ZP_W-1:0] Z_HALF = ZP_W'(1) <<< (FRACTION_BITS - 1);

    logic                           s1_valid_reg;
    cpc_tag_t                       s1_tag_reg, s1_tag_next;
    logic signed [DATA_WIDTH-1:0]   s1_a_reg, s1_b_reg;
    logic signed [ZP_W-1:0]         s1_zprod_reg, s1_zprod_next;
    logic [GP_W-1:0]                s1_gprod_reg, s1_gprod_next;

    logic                           s2_valid_reg;
    cpc_tag_t                       s2_tag_reg;
    cpc_vec_t                       s2_vec_reg, s2_vec_next;

    logic signed [ZP_W-1:0]         z_round;
    logic signed [W-1:0]            x_pol;
    logic signed [ZW-1:0]           z_pol;

    // stage 1: checks and products
    always_comb
    begin
        s1_tag_next.mode    = command;
        s1_tag_next.invalid = !command && (first_value < 0 || second_value > PI_BOUND
                                           || second_value < PI_BOUND_NEG);
        s1_tag_next.origin  = command && first_value == '0 && second_value == '0;
        s1_zprod_next       = ZP_W'(second_value) * ZP_W'(INV_TWO_PI_Q32);
        s1_gprod_next       = GP_W'(first_value[DATA_WIDTH-2:0]) * GP_W'(GAIN_Q24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg   <= s1_tag_next;
        s1_a_reg     <= first_value;
        s1_b_reg     <= second_value;
        s1_zprod_reg <= s1_zprod_next;
        s1_gprod_reg <= s1_gprod_next;
    end

    // stage 2: initial rotation vector
    always_comb
    begin
        z_round = (s1_zprod_reg + Z_HALF) >>> FRACTION_BITS;
        z_pol   = z_round[ZW-1:0];
        x_pol   = W'(s1_gprod_reg >> (GAIN_SHIFT - GUARD));
        if (s1_tag_reg.mode)
        begin
            s2_vec_next.x = W'(s1_a_reg) <<< GUARD;
            s2_vec_next.y = W'(s1_b_reg) <<< GUARD;
            s2_vec_next.z = '0;
            if (s1_a_reg < 0)
            begin
                s2_vec_next.x = -s2_vec_next.x;
                s2_vec_next.y = -s2_vec_next.y;
                s2_vec_next.z = (s1_b_reg >= 0) ? TURN_HALF : TURN_HALF_NEG;
            end
        end
        else
        begin
            s2_vec_next.y = '0;
            priority if (z_pol > TURN_QUARTER)
            begin
                s2_vec_next.x = -x_pol;
                s2_vec_next.z = z_pol - TURN_HALF;
            end
            else if (z_pol < TURN_QUARTER_NEG)
            begin
                s2_vec_next.x = -x_pol;
                s2_vec_next.z = z_pol + TURN_HALF;
            end
            else
            begin
                s2_vec_next.x = x_pol;
                s2_vec_next.z = z_pol;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_tag_reg <= s1_tag_reg;
        s2_vec_reg <= s2_vec_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_tag   = s2_tag_reg;
    assign out_vec   = s2_vec_reg;

endmodule

### sv/cpc_core.sv
// cpc_core: CORDIC pipeline, one register stage per iteration.
// Rotation or vectoring chosen per item by the tag. Depends on cpc_pkg.
module cpc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cpc_pkg::cpc_tag_t   in_tag,
    input  cpc_pkg::cpc_vec_t   in_vec,
    output logic                out_valid,
    output cpc_pkg::cpc_tag_t   out_tag,
    output cpc_pkg::cpc_vec_t   out_vec
);
    import cpc_pkg::*;

    logic     valid_reg [ITERATIONS];
    cpc_tag_t tag_reg   [ITERATIONS];
    cpc_vec_t vec_reg   [ITERATIONS];

    logic     valid_src [ITERATIONS];
    cpc_tag_t tag_src   [ITERATIONS];
    cpc_vec_t vec_src   [ITERATIONS];

    assign valid_src[0] = in_valid;
    assign tag_src[0]   = in_tag;
    assign vec_src[0]   = in_vec;

    for (genvar i = 1; i < ITERATIONS; i++)
    begin : g_link
        assign valid_src[i] = valid_reg[i-1];
        assign tag_src[i]   = tag_reg[i-1];
        assign vec_src[i]   = vec_reg[i-1];
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_UNITS[i]);

        logic signed [W-1:0]  x_cur, y_cur, x_sh, y_sh;
        logic signed [ZW-1:0] z_cur;
        logic                 pos;
        cpc_vec_t             vec_next;

        always_comb
        begin
            x_cur = vec_src[i].x;
            y_cur = vec_src[i].y;
            z_cur = vec_src[i].z;
            x_sh  = x_cur >>> i;
            y_sh  = y_cur >>> i;
            pos   = tag_src[i].mode ? (y_cur < 0) : (z_cur >= 0);
            if (pos)
            begin
                vec_next.x = x_cur - y_sh;
                vec_next.y = y_cur + x_sh;
                vec_next.z = z_cur - ATAN_STEP;
            end
            else
            begin
                vec_next.x = x_cur + y_sh;
                vec_next.y = y_cur - x_sh;
                vec_next.z = z_cur + ATAN_STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= valid_src[i];
        end

        always_ff @(posedge clk)
        begin
            tag_reg[i] <= tag_src[i];
            vec_reg[i] <= vec_next;
        end
    end

    assign out_valid = valid_reg[ITERATIONS-1];
    assign out_tag   = tag_reg[ITERATIONS-1];
    assign out_vec   = vec_reg[ITERATIONS-1];

endmodule

### sv/cpc_post.sv
// cpc_post: gain correction, angle to radians, rounding and saturation.
// Three register stages ending in the output registers. Depends on cpc_pkg.
module cpc_post (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  cpc_pkg::cpc_tag_t                      in_tag,
    input  cpc_pkg::cpc_vec_t                      in_vec,
    output logic                                   done,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0]  first_result,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0]  second_result,
    output logic                                   invalid_polar
);
    import cpc_pkg::*;

    localparam logic signed [ZM_W-1:0] ANG_HALF = ZM_W'(1) <<< (ANG_SHIFT - 1);

    logic                          p1_valid_reg;
    cpc_tag_t                      p1_tag_reg;
    logic signed [W-1:0]           p1_x_reg, p1_y_reg;
    logic signed [ZM_W-1:0]        p1_zmul_reg, p1_zmul_next;
    logic [W-1:0]                  p1_hp_reg, p1_hp_next;
    logic [2*GAIN_SHIFT-1:0]       p1_lp_reg, p1_lp_next;
    logic signed [ZW-1:0]          z_clamp;
    logic [W-1:0]                  x_u;

    logic                          p2_valid_reg;
    cpc_tag_t                      p2_tag_reg;
    logic signed [W:0]             p2_v1_reg, p2_v1_next;
    logic signed [W-1:0]           p2_v2_reg;
    logic signed [DATA_WIDTH-1:0]  p2_ang_reg, p2_ang_next;
    logic [W:0]                    mag;
    logic signed [ZM_W-1:0]        ang_full;

    logic                          done_reg;
    logic signed [DATA_WIDTH-1:0]  first_reg, first_next;
    logic signed [DATA_WIDTH-1:0]  second_reg, second_next;
    logic                          invalid_reg;

    // P1: clamp and scale angle, split gain multiply
    always_comb
    begin
        priority if (in_vec.z > TURN_HALF)
            z_clamp = TURN_HALF;
        else if (in_vec.z < TURN_HALF_NEG)
            z_clamp = TURN_HALF_NEG;
        else
            z_clamp = in_vec.z;
        p1_zmul_next = ZM_W'(z_clamp) * ZM_W'(TWO_PI_Q28);
        x_u          = in_vec.x;
        p1_hp_next   = W'(x_u[W-1:GAIN_SHIFT]) * W'(GAIN_Q24);
        p1_lp_next   = (2*GAIN_SHIFT)'(x_u[GAIN_SHIFT-1:0]) * (2*GAIN_SHIFT)'(GAIN_Q24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        p1_tag_reg  <= in_tag;
        p1_x_reg    <= in_vec.x;
        p1_y_reg    <= in_vec.y;
        p1_zmul_reg <= p1_zmul_next;
        p1_hp_reg   <= p1_hp_next;
        p1_lp_reg   <= p1_lp_next;
    end

    // P2: finish magnitude, radians
    always_comb
    begin
        mag         = (W+1)'(p1_hp_reg) + (W+1)'(p1_lp_reg >> GAIN_SHIFT);
        p2_v1_next  = p1_tag_reg.mode ? $signed(mag) : (W+1)'(p1_x_reg);
        ang_full    = (p1_zmul_reg + ANG_HALF) >>> ANG_SHIFT;
        p2_ang_next = ang_full[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p2_tag_reg <= p1_tag_reg;
        p2_v1_reg  <= p2_v1_next;
        p2_v2_reg  <= p1_y_reg;
        p2_ang_reg <= p2_ang_next;
    end

    // P3: round, saturate, force zero on rejected polar input and origin
    always_comb
    begin
        if (p2_tag_reg.invalid || p2_tag_reg.origin)
        begin
            first_next  = '0;
            second_next = '0;
        end
        else
        begin
            first_next  = round_sat(p2_v1_reg);
            second_next = p2_tag_reg.mode ? p2_ang_reg : round_sat((W+1)'(p2_v2_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        first_reg   <= first_next;
        second_reg  <= second_next;
        invalid_reg <= p2_tag_reg.invalid;
    end

    assign done          = done_reg;
    assign first_result  = first_reg;
    assign second_result = second_reg;
    assign invalid_polar = invalid_reg;

endmodule

### sv/polar_cartesian_converter.sv
// polar_cartesian_converter: top level, pipelined CORDIC polar/Cartesian converter.
// Instantiates cpc_pre, cpc_core and cpc_post; depends on cpc_pkg.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  command  | start, busy         | command, first_value, second_value
//  result   | done (1-cycle)      | first_result, second_result, invalid_polar
//
// One item enters per cycle; busy stays low.
// One register stage per CORDIC iteration lies between the entry and exit stages.
// Results leave in order, one strobe each; the receiver cannot stall.
// rst_n clears only the valid bits; items in flight are dropped.
module polar_cartesian_converter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   command,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0]  first_value,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0]  second_value,
    output logic                                   done,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0]  first_result,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0]  second_result,
    output logic                                   invalid_polar
);
    import cpc_pkg::*;

    logic     pre_valid, core_valid;
    cpc_tag_t pre_tag, core_tag;
    cpc_vec_t pre_vec, core_vec;

    assign busy = 1'b0;

    cpc_pre u_pre (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .command      (command),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (pre_valid),
        .out_tag      (pre_tag),
        .out_vec      (pre_vec)
    );

    cpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid),
        .in_tag    (pre_tag),
        .in_vec    (pre_vec),
        .out_valid (core_valid),
        .out_tag   (core_tag),
        .out_vec   (core_vec)
    );

    cpc_post u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (core_valid),
        .in_tag        (core_tag),
        .in_vec        (core_vec),
        .done          (done),
        .first_result  (first_result),
        .second_result (second_result),
        .invalid_polar (invalid_polar)
    );

endmodule

### sv/cpc_checker.sv
// cpc_port_checker: port-level assertions for polar_cartesian_converter, bound to the top.
// Depends on cpc_pkg for widths and pipeline latency.
module cpc_port_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   command,
    input logic signed [cpc_pkg::DATA_WIDTH-1:0]  first_value,
    input logic signed [cpc_pkg::DATA_WIDTH-1:0]  second_value,
    input logic                                   done,
    input logic signed [cpc_pkg::DATA_WIDTH-1:0]  first_result,
    input logic signed [cpc_pkg::DATA_WIDTH-1:0]  second_result,
    input logic                                   invalid_polar
);
    import cpc_pkg::*;

    // every result strobe traces back to an item taken on start while busy was low
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching item");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid_polar) |-> (first_result == '0 && second_result == '0))
        else $error("rejected polar item gave nonzero result");

    a_invalid_polar_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid_polar) |-> $past(!command, LATENCY))
        else $error("error flag on a Cartesian item");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(command && first_value == '0 && second_value == '0, LATENCY))
        |-> (first_result == '0 && second_result == '0 && !invalid_polar))
        else $error("origin did not give zero magnitude and angle");

endmodule

bind polar_cartesian_converter cpc_port_checker u_checker (.*);
